// ----- sv/sfaop_pkg.sv -----
// Shared constants and types of the spectrum frame averaging block.
package sfaop_pkg;

    localparam int unsigned PIXELS     = 288;
    localparam int unsigned POS_W      = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int unsigned SAMPLE_W   = 10;
    localparam int unsigned MODE_W     = 2;
    localparam int unsigned SUM_W      = 12;
    localparam int unsigned INDEX_W    = 9;
    localparam int unsigned REG_IDX_W  = 2;
    localparam int unsigned GROUP_W    = 2;

    typedef logic [POS_W-1:0]     pos_t;
    typedef logic [SAMPLE_W-1:0]  sample_t;
    typedef logic [MODE_W-1:0]    mode_t;
    typedef logic [SUM_W-1:0]     sum_t;
    typedef logic [INDEX_W-1:0]   index_t;
    typedef logic [REG_IDX_W-1:0] reg_idx_t;
    typedef logic [GROUP_W-1:0]   group_t;

    localparam mode_t MODE_SINGLE_MEAS = 2'd0;
    localparam mode_t MODE_SINGLE_BASE = 2'd1;
    localparam mode_t MODE_AVG_MEAS    = 2'd2;
    localparam mode_t MODE_AVG_BASE    = 2'd3;

    localparam reg_idx_t REG_OFFSET     = 2'd0;
    localparam reg_idx_t REG_SATURATION = 2'd1;

    localparam group_t GROUP_LAST = 2'd3;
    localparam int unsigned AVG_SHIFT = 2;

    localparam pos_t    POS_LAST        = POS_W'(PIXELS - 1);
    localparam sample_t SATURATION_INIT = '1;

endpackage

// ----- sv/sfaop_if.sv -----
// Stream and configuration channel interfaces of the spectrum frame averaging block.
interface sfaop_in_if;
    logic                valid;
    logic                ready;
    sfaop_pkg::sample_t  sample;
    sfaop_pkg::mode_t    mode;

    modport source (output valid, output sample, output mode, input ready);
    modport sink   (input valid, input sample, input mode, output ready);
endinterface

interface sfaop_out_if;
    logic                valid;
    logic                ready;
    sfaop_pkg::index_t   pixel_index;
    sfaop_pkg::sample_t  value;
    logic                to_baseline;
    logic                last;
    logic                overexposed;
    sfaop_pkg::index_t   peak_channel;
    logic                has_baseline;

    modport source (output valid, output pixel_index, output value, output to_baseline,
                    output last, output overexposed, output peak_channel,
                    output has_baseline, input ready);
    modport sink   (input valid, input pixel_index, input value, input to_baseline,
                    input last, input overexposed, input peak_channel,
                    input has_baseline, output ready);
endinterface

interface sfaop_cfg_if;
    logic                  valid;
    logic                  ready;
    sfaop_pkg::reg_idx_t   index;
    sfaop_pkg::sample_t    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/spectrum_frame_average_offset_peak.sv -----
// Top level: frame averaging with dark offset correction and peak search.
//
//  channel   dir  protocol      word contents
//  -------   ---  ------------  ---------------------------------------------------
//  pix_in    in   valid/ready   sample, mode (mode read on first pixel of a frame)
//  pix_out   out  valid/ready   pixel_index, value, to_baseline, last, overexposed,
//                               peak_channel, has_baseline
//  cfg       in   valid/ready   index (0 offset, 1 saturation), data
//
//  One word is accepted per cycle while pix_out does not stall. The accepting edge
//  issues the memory read and loads the update stage; when the update stage advances,
//  the sum is written back and the output register is loaded, raising pix_out.valid.
//  The rate is set by the per-pixel sum memory: one read and one write each cycle.
//  A stall on pix_out backs up through the update stage into pix_in.ready.
//  Reset clears frame counters and flags; the sum memory needs no clearing pass.
module spectrum_frame_average_offset_peak (
    input  logic          clk,
    input  logic          rst_n,
    sfaop_in_if.sink      pix_in,
    sfaop_out_if.source   pix_out,
    sfaop_cfg_if.sink     cfg
);

    typedef struct packed {
        sfaop_pkg::pos_t     pos;
        sfaop_pkg::sample_t  sample;
        logic                averaged;
        logic                fresh;      // first frame of a group: write, do not add
        logic                emit;
        logic                tb;
        logic                first;      // first pixel of a frame
        logic                last;
    } upd_t;

    // Configuration registers.
    sfaop_pkg::sample_t offset_reg;
    sfaop_pkg::sample_t saturation_reg;

    // Sequencing state.
    sfaop_pkg::pos_t    pos_reg;
    sfaop_pkg::mode_t   frame_mode_reg;
    sfaop_pkg::group_t  group_reg;
    logic               pending_reg;

    // Update stage.
    logic               upd_valid_reg;
    upd_t               upd_reg;
    sfaop_pkg::sum_t    rd_data_reg;
    logic               fwd_hit_reg;
    sfaop_pkg::sum_t    fwd_data_reg;

    // Per-frame tracking.
    sfaop_pkg::sample_t frame_max_reg;
    sfaop_pkg::pos_t    peak_reg;
    logic               over_reg;
    logic               stored_reg;

    // Output register.
    logic               out_valid_reg;
    sfaop_pkg::index_t  out_index_reg;
    sfaop_pkg::sample_t out_value_reg;
    logic               out_tb_reg;
    logic               out_last_reg;
    logic               out_over_reg;
    sfaop_pkg::index_t  out_peak_reg;
    logic               out_stored_reg;

    // Per-pixel sum store.
    sfaop_pkg::sum_t    sum_mem [sfaop_pkg::PIXELS];

    logic               accept;
    logic               upd_adv;
    logic               mem_we;
    upd_t               upd_next;
    logic               first_in;
    sfaop_pkg::mode_t   mode_eff;
    logic               pending_eff;
    logic               avg_in;
    logic               last_in;

    sfaop_pkg::sum_t    old_sum;
    sfaop_pkg::sum_t    sum_next;
    sfaop_pkg::sample_t v;
    sfaop_pkg::sample_t corr;
    sfaop_pkg::sample_t frame_max_next;
    sfaop_pkg::pos_t    peak_next;
    logic               over_next;
    logic               stored_next;

    // ---------------------------------------------------------------------
    // Handshakes: the update stage drains when the word makes no result or the
    // output register is free or being taken in this cycle.
    // ---------------------------------------------------------------------
    assign cfg.ready     = 1'b1;
    assign upd_adv       = upd_valid_reg && (!upd_reg.emit || !out_valid_reg || pix_out.ready);
    assign pix_in.ready  = !upd_valid_reg || upd_adv;
    assign accept        = pix_in.valid && pix_in.ready;
    assign mem_we        = upd_adv && upd_reg.averaged;

    // ---------------------------------------------------------------------
    // Sequencing: latch the frame mode on the first pixel, track the group.
    // ---------------------------------------------------------------------
    always_comb
    begin
        first_in    = (pos_reg == '0);
        mode_eff    = first_in ? pix_in.mode : frame_mode_reg;
        pending_eff = pending_reg || (first_in && pix_in.mode == sfaop_pkg::MODE_AVG_BASE);
        avg_in      = (mode_eff == sfaop_pkg::MODE_AVG_MEAS) ||
                      (mode_eff == sfaop_pkg::MODE_AVG_BASE);
        last_in     = (pos_reg == sfaop_pkg::POS_LAST);

        upd_next.pos      = pos_reg;
        upd_next.sample   = pix_in.sample;
        upd_next.averaged = avg_in;
        upd_next.fresh    = (group_reg == '0);
        upd_next.emit     = !avg_in || (group_reg == sfaop_pkg::GROUP_LAST);
        upd_next.tb       = avg_in ? pending_eff : (mode_eff == sfaop_pkg::MODE_SINGLE_BASE);
        upd_next.first    = first_in;
        upd_next.last     = last_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg     <= '0;
            saturation_reg <= sfaop_pkg::SATURATION_INIT;
            pos_reg        <= '0;
            frame_mode_reg <= sfaop_pkg::MODE_SINGLE_MEAS;
            group_reg      <= '0;
            pending_reg    <= 1'b0;
            upd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    sfaop_pkg::REG_OFFSET:     offset_reg     <= cfg.data;
                    sfaop_pkg::REG_SATURATION: saturation_reg <= cfg.data;
                    default: ;
                endcase
            end

            if (accept)
            begin
                frame_mode_reg <= mode_eff;
                if (last_in)
                begin
                    pos_reg <= '0;
                    if (avg_in)
                    begin
                        group_reg   <= group_reg + 1'b1;
                        pending_reg <= (group_reg == sfaop_pkg::GROUP_LAST) ? 1'b0 : pending_eff;
                    end
                    else
                    begin
                        pending_reg <= pending_eff;
                    end
                end
                else
                begin
                    pos_reg     <= pos_reg + 1'b1;
                    pending_reg <= pending_eff;
                end
            end

            if (accept)
                upd_valid_reg <= 1'b1;
            else if (upd_adv)
                upd_valid_reg <= 1'b0;
        end
    end

    // Stage payload, memory read, and forward of a same-entry write-back
    // landing on the edge of the read.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            upd_reg      <= upd_next;
            rd_data_reg  <= sum_mem[pos_reg];
            fwd_hit_reg  <= mem_we && (upd_reg.pos == pos_reg);
            fwd_data_reg <= sum_next;
        end
        if (mem_we)
            sum_mem[upd_reg.pos] <= sum_next;
    end

    // ---------------------------------------------------------------------
    // Update: accumulate, average, check saturation, subtract offset, track peak.
    // ---------------------------------------------------------------------
    always_comb
    begin
        old_sum  = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
        sum_next = (upd_reg.fresh ? '0 : old_sum) + sfaop_pkg::SUM_W'(upd_reg.sample);
        v        = upd_reg.averaged ? sum_next[sfaop_pkg::AVG_SHIFT +: sfaop_pkg::SAMPLE_W]
                                    : upd_reg.sample;
        corr     = (v > offset_reg) ? (v - offset_reg) : '0;

        over_next      = upd_reg.first ? 1'b0 : over_reg;
        frame_max_next = upd_reg.first ? '0 : frame_max_reg;
        peak_next      = peak_reg;
        stored_next    = stored_reg;
        if (upd_reg.emit)
        begin
            if (v > saturation_reg)
                over_next = 1'b1;
            if (!upd_reg.tb && corr > frame_max_next)
            begin
                frame_max_next = corr;
                peak_next      = upd_reg.pos;
            end
            if (upd_reg.last && upd_reg.tb)
                stored_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_max_reg <= '0;
            peak_reg      <= '0;
            over_reg      <= 1'b0;
            stored_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (upd_adv)
            begin
                frame_max_reg <= frame_max_next;
                peak_reg      <= peak_next;
                over_reg      <= over_next;
                stored_reg    <= stored_next;
            end

            if (upd_adv && upd_reg.emit)
                out_valid_reg <= 1'b1;
            else if (pix_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Output word; hold while the sink stalls.
    always_ff @(posedge clk)
    begin
        if (upd_adv && upd_reg.emit)
        begin
            out_index_reg  <= sfaop_pkg::INDEX_W'(upd_reg.pos);
            out_value_reg  <= corr;
            out_tb_reg     <= upd_reg.tb;
            out_last_reg   <= upd_reg.last;
            out_over_reg   <= upd_reg.last && over_next;
            out_peak_reg   <= upd_reg.last ? sfaop_pkg::INDEX_W'(peak_next) : '0;
            out_stored_reg <= stored_next;
        end
    end

    assign pix_out.valid        = out_valid_reg;
    assign pix_out.pixel_index  = out_index_reg;
    assign pix_out.value        = out_value_reg;
    assign pix_out.to_baseline  = out_tb_reg;
    assign pix_out.last         = out_last_reg;
    assign pix_out.overexposed  = out_over_reg;
    assign pix_out.peak_channel = out_peak_reg;
    assign pix_out.has_baseline = out_stored_reg;

endmodule

// ----- bench/spectrum_frame_average_offset_peak_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the frame averaging, dark offset and peak search block.
module spectrum_frame_average_offset_peak_tb;
    import sfaop_pkg::*;

    // Cycles to let a word that yields no output clear the pipeline.
    localparam int DRAIN_CYCLES = 6;
    // Slowest correct run: 1152 words, with the sender gap and the receiver
    // stall both at their largest. Allow several times that.
    localparam int WATCHDOG_NS  = 250_000;

    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_HIGH} fill_t;

    // One output word, laid out field by field.
    typedef struct packed {
        index_t  pixel_index;
        sample_t value;
        logic    to_baseline;
        logic    last;
        logic    overexposed;
        index_t  peak_channel;
        logic    has_baseline;
    } pixel_word_t;

    // Predicts the output stream from the accepted input words and checks each
    // output word against the oldest prediction.
    class pixel_scoreboard;
        sum_t        acc_store [PIXELS];
        group_t      group_count;
        logic        baseline_due;
        int unsigned position;
        mode_t       frame_kind;
        sample_t     frame_top;
        pos_t        peak_pos;
        logic        frame_over;
        logic        baseline_seen;
        sample_t     offset;
        sample_t     saturation;
        pixel_word_t expected_words [$];
        int          failures;

        function new();
            foreach (acc_store[i])
                acc_store[i] = '0;
            group_count   = '0;
            baseline_due  = 1'b0;
            position      = 0;
            frame_kind    = MODE_SINGLE_MEAS;
            frame_top     = '0;
            peak_pos      = '0;
            frame_over    = 1'b0;
            baseline_seen = 1'b0;
            offset        = '0;
            saturation    = SATURATION_INIT;
            failures      = 0;
        endfunction

        function void set_register(reg_idx_t idx, sample_t data);
            if (idx == REG_OFFSET)
                offset = data;
            else if (idx == REG_SATURATION)
                saturation = data;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function string show(pixel_word_t w);
            return $sformatf("idx=%0d val=%0d base=%0b last=%0b over=%0b peak=%0d hasb=%0b",
                             w.pixel_index, w.value, w.to_baseline, w.last,
                             w.overexposed, w.peak_channel, w.has_baseline);
        endfunction

        function void note_sample(sample_t s, mode_t m);
            int unsigned pos;
            logic        averaged;
            logic        at_end;
            logic        emit;
            logic        to_base;
            sample_t     v;
            sample_t     c;
            sum_t        acc;
            pixel_word_t w;

            emit    = 1'b0;
            to_base = 1'b0;
            v       = '0;
            pos     = (position >= PIXELS) ? 0 : position;

            // Latch the frame mode on the first pixel; later mode fields are ignored.
            if (pos == 0)
            begin
                frame_kind = m;
                frame_top  = '0;
                frame_over = 1'b0;
                if (m == MODE_AVG_BASE)
                    baseline_due = 1'b1;
            end
            averaged = (frame_kind == MODE_AVG_MEAS) || (frame_kind == MODE_AVG_BASE);
            at_end   = (pos == PIXELS - 1);

            if (!averaged)
            begin
                // Single frames pass straight through and leave the group alone.
                emit    = 1'b1;
                v       = s;
                to_base = (frame_kind == MODE_SINGLE_BASE);
            end
            else
            begin
                // First frame of a group overwrites the store, the rest accumulate.
                acc = (group_count == 0) ? sum_t'(s) : acc_store[pos] + s;
                acc_store[pos] = acc;
                if (group_count == GROUP_LAST)
                begin
                    emit    = 1'b1;
                    v       = sample_t'(acc >> AVG_SHIFT);
                    to_base = baseline_due;
                end
            end

            c = '0;
            if (emit)
            begin
                if (v > saturation)
                    frame_over = 1'b1;
                c = (v > offset) ? v - offset : '0;
                // Keep the first strictly greatest measurement pixel.
                if (!to_base && c > frame_top)
                begin
                    frame_top = c;
                    peak_pos  = pos_t'(pos);
                end
                if (at_end && to_base)
                    baseline_seen = 1'b1;
            end

            if (at_end)
            begin
                if (averaged)
                begin
                    if (group_count == GROUP_LAST)
                        baseline_due = 1'b0;
                    group_count = group_count + group_t'(1);
                end
                position = 0;
            end
            else
                position = pos + 1;

            if (!emit)
                return;
            w.pixel_index  = index_t'(pos);
            w.value        = c;
            w.to_baseline  = to_base;
            w.last         = at_end;
            w.overexposed  = at_end ? frame_over : 1'b0;
            w.peak_channel = at_end ? index_t'(peak_pos) : '0;
            w.has_baseline = baseline_seen;
            expected_words.push_back(w);
        endfunction

        function void check_word(pixel_word_t got);
            pixel_word_t want;

            if (expected_words.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("ERROR: unexpected output word: %s", show(got));
                return;
            end
            want = expected_words.pop_front();
            if (got !== want)
            begin
                failures++;
                if (failures <= 10)
                    $display("ERROR: output mismatch\n  expected %s\n  actual   %s",
                             show(want), show(got));
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    sfaop_in_if  pix_in ();
    sfaop_out_if pix_out ();
    sfaop_cfg_if cfg ();

    spectrum_frame_average_offset_peak dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in),
        .pix_out (pix_out),
        .cfg     (cfg)
    );

    pixel_scoreboard sb;
    int              send_burst;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #(WATCHDOG_NS);
        $display("Simulation FAILED");
        $finish;
    end

    // Draw a random per-word wait, with occasional back-to-back stretches.
    function automatic int draw_gap(inout int burst_left);
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 49) == 0)
        begin
            burst_left = $urandom_range(20, 150);
            return 0;
        end
        return $urandom_range(0, 10);
    endfunction

    function automatic sample_t draw_sample(fill_t fill);
        case (fill)
            FILL_ZERO: return '0;
            FILL_HIGH: return ($urandom_range(0, 2) == 0) ? '1 : sample_t'($urandom_range(900, 1023));
            default:
            begin
                case ($urandom_range(0, 7))
                    0:       return '0;
                    1:       return '1;
                    default: return sample_t'($urandom_range(0, 1023));
                endcase
            end
        endcase
    endfunction

    function automatic fill_t draw_fill();
        case ($urandom_range(0, 9))
            0:       return FILL_ZERO;
            1, 2:    return FILL_HIGH;
            default: return FILL_RANDOM;
        endcase
    endfunction

    // Present one word, hold it until accepted, then note it for prediction.
    task automatic send_word(sample_t s, mode_t m);
        int gap;

        gap = draw_gap(send_burst);
        if (gap > 0)
        begin
            pix_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_in.valid  <= 1'b1;
        pix_in.sample <= s;
        pix_in.mode   <= m;
        @(posedge clk);
        while (!pix_in.ready)
            @(posedge clk);
        sb.note_sample(s, m);
    endtask

    // Send one whole frame; only the first word's mode counts, the rest carry noise.
    task automatic send_frame(mode_t m, fill_t fill);
        for (int i = 0; i < PIXELS; i++)
            send_word(draw_sample(fill), (i == 0) ? m : mode_t'($urandom_range(0, 3)));
    endtask

    // Drop valid and wait until every predicted word is out and the pipeline is empty.
    task automatic wait_drained();
        pix_in.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write both registers back to back while the block is idle.
    task automatic write_settings(sample_t offset_val, sample_t saturation_val);
        wait_drained();
        cfg.valid <= 1'b1;
        cfg.index <= REG_OFFSET;
        cfg.data  <= offset_val;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        sb.set_register(REG_OFFSET, offset_val);
        cfg.index <= REG_SATURATION;
        cfg.data  <= saturation_val;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        sb.set_register(REG_SATURATION, saturation_val);
        cfg.valid <= 1'b0;
    endtask

    // Output side: stall a random number of cycles per word, then take it and check it.
    initial
    begin
        pixel_word_t got;
        int          stall;
        int          sink_burst;

        sink_burst    = 0;
        pix_out.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = draw_gap(sink_burst);
            if (stall > 0)
            begin
                pix_out.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pix_out.ready <= 1'b1;
            @(posedge clk);
            while (!pix_out.valid)
                @(posedge clk);
            got.pixel_index  = pix_out.pixel_index;
            got.value        = pix_out.value;
            got.to_baseline  = pix_out.to_baseline;
            got.last         = pix_out.last;
            got.overexposed  = pix_out.overexposed;
            got.peak_channel = pix_out.peak_channel;
            got.has_baseline = pix_out.has_baseline;
            sb.check_word(got);
        end
    end

    // Stimulus: one averaged group of four frames, 1152 words in all.
    initial
    begin
        sb            = new();
        send_burst    = 0;
        rst_n         <= 1'b0;
        pix_in.valid  <= 1'b0;
        pix_in.sample <= '0;
        pix_in.mode   <= MODE_SINGLE_MEAS;
        cfg.valid     <= 1'b0;
        cfg.index     <= REG_OFFSET;
        cfg.data      <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Moderate offset and saturation so that flooring, overexposure and the
        // peak search all see both outcomes. A full-scale frame pushes the sum
        // near its top, and the third frame may turn the group into baseline.
        write_settings(sample_t'($urandom_range(0, 200)), sample_t'($urandom_range(600, 1000)));
        send_frame(MODE_AVG_MEAS, FILL_RANDOM);
        send_frame(MODE_AVG_MEAS, FILL_HIGH);
        send_frame($urandom_range(0, 1) ? MODE_AVG_BASE : MODE_AVG_MEAS, draw_fill());
        send_frame(MODE_AVG_MEAS, draw_fill());

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
